// ===== rtl/core/life_automaton_step_core_defines.svh =====
// Assertion macros shared by the life automaton step core.
`ifndef LIFE_AUTOMATON_STEP_CORE_DEFINES_SVH
`define LIFE_AUTOMATON_STEP_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIFESTEP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lifestep same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LIFESTEP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lifestep next-cycle check failed");

`endif

// ===== rtl/core/lifestep_pkg.sv =====
// Types and codes shared by the life automaton step core.
package lifestep_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] row;
		logic [5:0] column;
		logic       cell_in;
	} req_t;

	typedef struct packed {
		logic cell_out;
		logic done_res;
	} rsp_t;

	// One grid column as seen by a sweep cell: old rows above, current and below.
	typedef struct packed {
		logic above;
		logic cur;
		logic below;
	} col_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== rtl/core/life_automaton_step_core.sv =====
// Top level of the life automaton step core: request decode, sweep sequencer and response register.
// The grid lives in a row memory with one read and one write port. A write request reads its row,
// modifies it and writes it back, then posts the response; a read request reads its row, captures
// the bit and posts the response. An off-grid access or an unused opcode goes straight to the response.
// An advance request loads row zero into the row of GRID_SIZE column cells, then sweeps one row per
// cycle while the next row is fetched and the new row is written back, then posts the response.
// The grid is dead after reset at once through per-row valid bits, so there is no clearing pass.
// A new request is taken while the previous response still waits to be collected.
`include "life_automaton_step_core_defines.svh"

module life_automaton_step_core #(
	parameter int unsigned GRID_SIZE = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  lifestep_pkg::req_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output lifestep_pkg::rsp_t  rsp
);

	localparam int unsigned IW = $clog2(GRID_SIZE);
	localparam int unsigned AW = (IW > 6) ? IW : 6;
	localparam logic [IW-1:0] LAST_ROW = IW'(GRID_SIZE - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRMOD,
		S_RDWAIT,
		S_FILL,
		S_SWEEP,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [IW-1:0]      cnt_q;
	logic [IW-1:0]      row_q;
	logic [IW-1:0]      col_q;
	logic               bit_q;
	lifestep_pkg::rsp_t res_q;
	lifestep_pkg::rsp_t rsp_q;
	logic               rsp_valid_q;

	logic                   acc;
	logic [AW:0]            row_w;
	logic [AW:0]            col_w;
	logic                   on_grid;
	logic [IW-1:0]          row_idx;
	logic [IW-1:0]          col_idx;
	logic [IW:0]            next_rd;
	logic                   mem_wr_en;
	logic [IW-1:0]          mem_wr_addr;
	logic [GRID_SIZE-1:0]   mem_wr_data;
	logic                   mem_rd_en;
	logic [IW-1:0]          mem_rd_addr;
	logic [GRID_SIZE-1:0]   rd_data;
	logic [GRID_SIZE-1:0]   feed;
	logic [GRID_SIZE-1:0]   next_row;
	logic [GRID_SIZE-1:0]   mod_row;
	lifestep_pkg::cell_ctl_t ctl;
	lifestep_pkg::col_t     nb [GRID_SIZE+2];

	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign row_w   = (AW+1)'(req.row);
	assign col_w   = (AW+1)'(req.column);
	assign on_grid = (row_w < (AW+1)'(GRID_SIZE)) && (col_w < (AW+1)'(GRID_SIZE));
	assign row_idx = row_w[IW-1:0];
	assign col_idx = col_w[IW-1:0];
	assign next_rd = (IW+1)'(cnt_q) + (IW+1)'(2);

	// Below the last row lies only dead space.
	assign feed = ((state_q == S_SWEEP) && (cnt_q == LAST_ROW)) ? '0 : rd_data;

	always_comb begin
		mod_row         = rd_data;
		mod_row[col_q]  = bit_q;
		mem_rd_en       = 1'b0;
		mem_rd_addr     = row_idx;
		mem_wr_en       = 1'b0;
		mem_wr_addr     = row_q;
		mem_wr_data     = mod_row;
		ctl             = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && on_grid
						&& (req.opcode == lifestep_pkg::OP_WRITE
						|| req.opcode == lifestep_pkg::OP_READ)) begin
					mem_rd_en = 1'b1;
				end
				if (acc && (req.opcode == lifestep_pkg::OP_STEP)) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = '0;
				end
			end
			S_WRMOD: begin
				mem_wr_en = 1'b1;
			end
			S_FILL: begin
				ctl.load    = 1'b1;
				mem_rd_en   = 1'b1;
				mem_rd_addr = IW'(1);
			end
			S_SWEEP: begin
				ctl.shift   = 1'b1;
				mem_wr_en   = 1'b1;
				mem_wr_addr = cnt_q;
				mem_wr_data = next_row;
				if (next_rd < (IW+1)'(GRID_SIZE)) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = next_rd[IW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	lifestep_rowmem #(
		.GRID_SIZE(GRID_SIZE)
	) u_rowmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	assign nb[0]           = '0;
	assign nb[GRID_SIZE+1] = '0;

	for (genvar i = 0; i < GRID_SIZE; i++) begin : g_cell
		lifestep_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.feed  (feed[i]),
			.left  (nb[i]),
			.right (nb[i+2]),
			.own   (nb[i+1]),
			.nxt   (next_row[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			bit_q       <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// In the done state the response register is refilled below instead.
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						row_q <= row_idx;
						col_q <= col_idx;
						bit_q <= req.cell_in;
						case (req.opcode)
							lifestep_pkg::OP_WRITE: begin
								res_q   <= '{cell_out: 1'b0, done_res: 1'b1};
								state_q <= on_grid ? S_WRMOD : S_DONE;
							end
							lifestep_pkg::OP_READ: begin
								res_q   <= '{cell_out: 1'b0, done_res: 1'b1};
								state_q <= on_grid ? S_RDWAIT : S_DONE;
							end
							lifestep_pkg::OP_STEP: begin
								state_q <= S_FILL;
							end
							default: begin
								res_q   <= '{cell_out: 1'b0, done_res: 1'b0};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WRMOD: begin
					state_q <= S_DONE;
				end
				S_RDWAIT: begin
					res_q   <= '{cell_out: rd_data[col_q], done_res: 1'b1};
					state_q <= S_DONE;
				end
				S_FILL: begin
					cnt_q   <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (cnt_q == LAST_ROW) begin
						res_q   <= '{cell_out: 1'b0, done_res: 1'b1};
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`LIFESTEP_ASSERT_NOW(a_sweep_writes_row, state_q == S_SWEEP, mem_wr_en && mem_wr_addr == cnt_q)
	`LIFESTEP_ASSERT_NEXT(a_step_fetches, acc && req.opcode == lifestep_pkg::OP_STEP, state_q == S_FILL)
	`LIFESTEP_ASSERT_NEXT(a_sweep_ends, state_q == S_SWEEP && cnt_q == LAST_ROW, state_q == S_DONE && res_q.done_res)

endmodule

// ===== rtl/core/lifestep_cell.sv =====
// One column cell of the sweep row: holds two old rows and computes the B3/S23 update.
module lifestep_cell (
	input  logic                   clk,
	input  lifestep_pkg::cell_ctl_t ctl,
	input  logic                   feed,
	input  lifestep_pkg::col_t     left,
	input  lifestep_pkg::col_t     right,
	output lifestep_pkg::col_t     own,
	output logic                   nxt
);

	logic       above_q;
	logic       cur_q;
	logic [3:0] count;

	assign own.above = above_q;
	assign own.cur   = cur_q;
	assign own.below = feed;

	always_comb begin
		count = 4'(left.above) + 4'(left.cur) + 4'(left.below)
			+ 4'(above_q) + 4'(feed)
			+ 4'(right.above) + 4'(right.cur) + 4'(right.below);
		nxt = (count == 4'd3) || (cur_q && (count == 4'd2));
	end

	// Loading starts a sweep with nothing above row zero.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			above_q <= 1'b0;
			cur_q   <= feed;
		end else if (ctl.shift) begin
			above_q <= cur_q;
			cur_q   <= feed;
		end
	end

endmodule

// ===== rtl/core/lifestep_rowmem.sv =====
// Row store of the grid, one row per word, with per-row valid bits that clear the grid at reset.
module lifestep_rowmem #(
	parameter int unsigned GRID_SIZE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(GRID_SIZE)-1:0] wr_addr,
	input  logic [GRID_SIZE-1:0]         wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(GRID_SIZE)-1:0] rd_addr,
	output logic [GRID_SIZE-1:0]         rd_data
);

	logic [GRID_SIZE-1:0] mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] rd_q;
	logic [GRID_SIZE-1:0] valid_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// A row never written since reset reads as all dead.
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
